// ===== rtl/cfbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and mask helpers for the crontab field bitmap parser.
// Used by cfbp_ctl, cfbp_dp, the top level and the checker; depends on nothing.
package cfbp_pkg;

   localparam int MAP_BITS  = 64;   // values at or above this are never set
   localparam int OUT_BITS  = 64;   // width of the result bitmap port
   localparam int NUM_W     = 6;    // first number, config registers
   localparam int SEC_W     = 7;    // second number, repeat step (up to 64)
   localparam int VAL_W     = 7;    // repeat walker value (up to 127)
   localparam int ACC_W     = 10;   // ten times a number plus a digit
   localparam int CSR_IDX_W = 2;
   localparam int CNT_W     = 2;

   typedef logic [NUM_W-1:0]    num_type;
   typedef logic [SEC_W-1:0]    sec_type;
   typedef logic [VAL_W-1:0]    val_type;
   typedef logic [ACC_W-1:0]    acc_type;
   typedef logic [MAP_BITS-1:0] map_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_MINUTE = 2'd2;

   localparam num_type MIN_RESET    = 6'd0;
   localparam num_type MAX_RESET    = 6'd59;
   localparam num_type MINUTE_RESET = 6'd0;
   localparam num_type QMARK_MAX    = 6'd59;   // '?' only legal for minute fields
   localparam cnt_type COUNT_MAX    = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_QMARK = 8'h3F;

   typedef enum logic [1:0] {
      STS_OK,
      STS_SYNTAX,
      STS_RANGE,
      STS_EMPTY
   } status_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_STAR,
      PH_QMARK,
      PH_FIRST,
      PH_RANGE_OPEN,
      PH_RANGE_NUM,
      PH_REP_OPEN,
      PH_REP_NUM,
      PH_DONE,
      PH_WILD
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_TERM,
      CS_SEEK,
      CS_FILL,
      CS_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic feed;        // run one parse step on the current byte
      logic feed_zero;   // step on a NUL instead of the input byte
      logic seek;        // move repeat walker onto its first value
      logic fill;        // set walker value, advance by step
      logic emit;        // load result register, clear field state
   } ctl_cmd_type;

   typedef struct packed {
      logic rep_start;   // this step closes a repeat term
      logic seek_done;
      logic fill_done;
      logic out_free;    // result register can take a new beat
      logic char_zero;   // input byte is NUL
   } dp_sts_type;

   function automatic acc_type times_ten_plus(acc_type base, logic [3:0] digit);
      return (base << 3) + (base << 1) + acc_type'(digit);
   endfunction

   function automatic map_type span_mask(val_type lo, val_type hi);
      map_type m;
      for (int i = 0; i < MAP_BITS; i++) begin
         m[i] = (val_type'(i) >= lo) && (val_type'(i) <= hi);
      end
      return m;
   endfunction

   function automatic map_type bit_mask(val_type v);
      map_type m;
      for (int i = 0; i < MAP_BITS; i++) begin
         m[i] = (val_type'(i) == v);
      end
      return m;
   endfunction

endpackage

// ===== rtl/cfbp_ctl.sv =====
`timescale 1ns / 1ps
// Sequencer for the crontab field parser: byte accept, end-of-field NUL step,
// repeat-term walk and result emit. Depends on cfbp_pkg.
module cfbp_ctl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_end_of_field,
   output logic                     req_stall,
   input  cfbp_pkg::dp_sts_type     sts,
   output cfbp_pkg::ctl_cmd_type    cmd
);
   import cfbp_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          term_pend_ff, term_pend_in;   // NUL step still owed
   logic          emit_pend_ff, emit_pend_in;   // result still owed

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         term_pend_ff <= 1'b0;
         emit_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_pend_ff <= term_pend_in;
         emit_pend_ff <= emit_pend_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      term_pend_in = term_pend_ff;
      emit_pend_in = emit_pend_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.feed     = 1'b1;
               term_pend_in = req_end_of_field && !sts.char_zero;
               emit_pend_in = req_end_of_field;
               if (sts.rep_start) begin
                  state_in = CS_SEEK;
               end else if (req_end_of_field && !sts.char_zero) begin
                  state_in = CS_TERM;
               end else if (req_end_of_field) begin
                  state_in = CS_EMIT;
               end
            end
         end
         CS_TERM: begin
            cmd.feed      = 1'b1;
            cmd.feed_zero = 1'b1;
            term_pend_in  = 1'b0;
            state_in      = sts.rep_start ? CS_SEEK : CS_EMIT;
         end
         CS_SEEK: begin
            cmd.seek = 1'b1;
            if (sts.seek_done) begin
               state_in = CS_FILL;
            end
         end
         CS_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_done) begin
               if (term_pend_ff) begin
                  state_in = CS_TERM;
               end else if (emit_pend_ff) begin
                  state_in = CS_EMIT;
               end else begin
                  state_in = CS_IDLE;
               end
            end
         end
         CS_EMIT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               emit_pend_in = 1'b0;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/cfbp_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the crontab field parser: config registers, parse step, bitmap,
// repeat-term walker and result register. Depends on cfbp_pkg.
module cfbp_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  cfbp_pkg::ctl_cmd_type             cmd,
   output cfbp_pkg::dp_sts_type              sts,
   input  logic [7:0]                        req_char_code,
   input  logic                              csr_write,
   input  logic [cfbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfbp_pkg::NUM_W-1:0]        csr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [cfbp_pkg::OUT_BITS-1:0]     rsp_value_set,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_was_wildcard
);
   import cfbp_pkg::*;

   // config
   num_type min_ff, max_ff, minute_ff;

   // field state
   phase_type  phase_ff, phase_in;
   num_type    first_ff, first_in;
   sec_type    second_ff, second_in;
   status_type err_ff, err_in;
   cnt_type    count_ff, count_in;
   map_type    set_ff, set_in;

   // repeat walker
   val_type walk_v_ff;
   sec_type walk_step_ff;

   // result register
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] value_ff, value_in;
   status_type          status_ff;
   logic                wild_ff;

   // step decode
   logic [7:0] ch;
   logic [3:0] digit;
   logic       is_term, is_digit, live, open_ph, range_side, second_bad, after_ok;
   acc_type    acc_first, acc_second;
   num_type    fin_val;
   phase_type  st_phase;
   num_type    st_first;
   sec_type    st_second;
   status_type st_err;
   cnt_type    st_count;
   map_type    st_mask;
   logic       st_rep;

   val_type lo, hi;
   logic    go_down, go_up, fill_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= MIN_RESET;
         max_ff    <= MAX_RESET;
         minute_ff <= MINUTE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FIELD_MIN:  min_ff    <= csr_data;
            CSR_FIELD_MAX:  max_ff    <= csr_data;
            CSR_CUR_MINUTE: minute_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ch         = cmd.feed_zero ? CH_NUL : req_char_code;
   assign is_term    = ch inside {CH_NUL, CH_SPACE, CH_TAB, CH_NL};
   assign is_digit   = ch inside {[CH_ZERO:CH_NINE]};
   assign digit      = 4'(ch - CH_ZERO);
   assign live       = (err_ff == STS_OK) && (phase_ff != PH_DONE) && (phase_ff != PH_WILD);
   assign open_ph    = (phase_ff == PH_RANGE_OPEN) || (phase_ff == PH_REP_OPEN);
   assign range_side = (phase_ff == PH_RANGE_OPEN) || (phase_ff == PH_RANGE_NUM);
   assign acc_first  = times_ten_plus(acc_type'(first_ff), digit);
   assign acc_second = times_ten_plus(open_ph ? '0 : acc_type'(second_ff), digit);
   assign fin_val    = (phase_ff == PH_QMARK) ? minute_ff : first_ff;

   // repeat step limit is max - min + 1, compared without going negative
   assign second_bad = range_side ? (acc_second > acc_type'(max_ff))
                     : ((acc_second + acc_type'(min_ff)) > (acc_type'(max_ff) + acc_type'(1)));

   // one parse step on ch; applied only under cmd.feed
   always_comb begin
      st_phase  = phase_ff;
      st_first  = first_ff;
      st_second = second_ff;
      st_err    = err_ff;
      st_mask   = '0;
      st_rep    = 1'b0;
      after_ok  = 1'b0;
      if (live) begin
         case (phase_ff)
            PH_START: begin
               if (is_term) begin
                  st_err = (count_ff == '0) ? STS_EMPTY : STS_SYNTAX;
               end else if (ch == CH_STAR && count_ff == '0) begin
                  st_phase = PH_STAR;
               end else if (ch == CH_QMARK && max_ff == QMARK_MAX) begin
                  st_phase = PH_QMARK;
               end else if (is_digit) begin
                  if (NUM_W'(digit) > max_ff) begin
                     st_err = STS_RANGE;
                  end else begin
                     st_first = NUM_W'(digit);
                     st_phase = PH_FIRST;
                  end
               end else begin
                  st_err = STS_SYNTAX;
               end
            end
            PH_STAR: begin
               if (is_term) begin
                  st_mask  = span_mask(val_type'(min_ff), val_type'(max_ff));
                  st_phase = PH_WILD;
               end else begin
                  st_err = STS_SYNTAX;
               end
            end
            PH_QMARK, PH_FIRST: begin
               if (phase_ff == PH_FIRST && is_digit) begin
                  if (acc_first > acc_type'(max_ff)) begin
                     st_err = STS_RANGE;
                  end else begin
                     st_first = NUM_W'(acc_first);
                  end
               end else if (phase_ff == PH_QMARK && ch == CH_DASH) begin
                  st_err = STS_SYNTAX;
               end else if (phase_ff == PH_QMARK && minute_ff > max_ff) begin
                  st_err = STS_RANGE;
               end else begin
                  // term start is complete
                  st_first = fin_val;
                  if (fin_val < min_ff) begin
                     st_err = STS_RANGE;
                  end else if (ch == CH_DASH) begin
                     st_phase = PH_RANGE_OPEN;
                  end else if (ch == CH_COLON) begin
                     st_phase = PH_REP_OPEN;
                  end else begin
                     st_mask  = bit_mask(val_type'(fin_val));
                     after_ok = 1'b1;
                  end
               end
            end
            PH_RANGE_OPEN, PH_REP_OPEN, PH_RANGE_NUM, PH_REP_NUM: begin
               if (is_digit) begin
                  if (second_bad) begin
                     st_err = STS_RANGE;
                  end else begin
                     st_second = SEC_W'(acc_second);
                     st_phase  = range_side ? PH_RANGE_NUM : PH_REP_NUM;
                  end
               end else if (open_ph) begin
                  st_err = STS_SYNTAX;
               end else if (range_side) begin
                  if (second_ff < SEC_W'(first_ff)) begin
                     st_err = STS_RANGE;
                  end else begin
                     st_mask  = span_mask(val_type'(first_ff), val_type'(second_ff));
                     after_ok = 1'b1;
                  end
               end else begin
                  if (second_ff == '0) begin
                     st_err = STS_RANGE;
                  end else begin
                     st_rep   = 1'b1;
                     after_ok = 1'b1;
                  end
               end
            end
            default: begin
               st_phase = PH_DONE;
            end
         endcase
         if (after_ok) begin
            if (is_term) begin
               st_phase = PH_DONE;
            end else if (ch == CH_COMMA) begin
               st_phase = PH_START;
            end else begin
               st_err = STS_SYNTAX;
            end
         end
         if (st_err != STS_OK) begin
            st_phase = PH_DONE;
         end
      end
   end

   assign st_count = (live && !is_term && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   // repeat walker: seek to first member of the class near min, then fill up to max
   assign lo        = val_type'(min_ff);
   assign hi        = val_type'(max_ff);
   assign go_down   = (walk_v_ff >= lo) && (walk_v_ff >= lo + val_type'(walk_step_ff));
   assign go_up     = (walk_v_ff < lo) && (walk_v_ff + val_type'(walk_step_ff) <= lo);
   assign fill_done = walk_v_ff > hi;

   always_ff @(posedge clock) begin
      if (cmd.feed && st_rep) begin
         walk_v_ff    <= val_type'(first_ff);
         walk_step_ff <= second_ff;
      end else if (cmd.seek) begin
         if (go_down) begin
            walk_v_ff <= walk_v_ff - val_type'(walk_step_ff);
         end else if (go_up) begin
            walk_v_ff <= walk_v_ff + val_type'(walk_step_ff);
         end
      end else if (cmd.fill && !fill_done) begin
         walk_v_ff <= walk_v_ff + val_type'(walk_step_ff);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      set_in    = set_ff;
      if (cmd.emit) begin
         phase_in  = PH_START;
         first_in  = '0;
         second_in = '0;
         err_in    = STS_OK;
         count_in  = '0;
         set_in    = '0;
      end else if (cmd.feed) begin
         phase_in  = st_phase;
         first_in  = st_first;
         second_in = st_second;
         err_in    = st_err;
         count_in  = st_count;
         set_in    = set_ff | st_mask;
      end else if (cmd.fill && !fill_done) begin
         set_in = set_ff | bit_mask(walk_v_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         first_ff  <= '0;
         second_ff <= '0;
         err_ff    <= STS_OK;
         count_ff  <= '0;
         set_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         err_ff    <= err_in;
         count_ff  <= count_in;
         set_ff    <= set_in;
      end
   end

   // result register
   always_comb begin
      value_in = '0;
      if (err_ff == STS_OK) begin
         value_in[MAP_BITS-1:0] = set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         value_ff  <= value_in;
         status_ff <= err_ff;
         wild_ff   <= (err_ff == STS_OK) && (phase_ff == PH_WILD);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_set    = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_was_wildcard = wild_ff;

   assign sts.rep_start = st_rep;
   assign sts.seek_done = !go_down && !go_up;
   assign sts.fill_done = fill_done;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.char_zero = (req_char_code == CH_NUL);

endmodule

// ===== rtl/cron_field_bitmap_parser.sv =====
`timescale 1ns / 1ps
// Sequence: a byte is taken while the sequencer is idle; an end beat that carries a character
//   is followed by a NUL step, then the emit step, held while an older result beat is still
//   stalled; the result beat is valid on the next cycle.
// Closing a repeat term n:m adds walker steps to the first value near the minimum, then one
//   fill step per value set. Throughput: one input beat per cycle while the sequencer is idle.
// Reset (synchronous): clears parse state and result valid; min 0, max 59, minute 0.
//
// Top level of the crontab time-field parser. Bytes of one field arrive one per beat; the
// last beat of a field carries end_of_field. The field is parsed on the fly into a bitmap of
// allowed values; single numbers, ranges and the lone star are set in the step that completes
// them, a repeat term walks its values one per cycle through a small adder loop.
// Depends on cfbp_pkg, cfbp_ctl and cfbp_dp.
module cron_field_bitmap_parser (
   input  logic                              clock,
   input  logic                              reset,
   // input bytes
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_char_code,
   input  logic                              req_end_of_field,
   // result beat
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cfbp_pkg::OUT_BITS-1:0]     rsp_value_set,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_was_wildcard,
   // config writes
   input  logic                              csr_write,
   input  logic [cfbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfbp_pkg::NUM_W-1:0]        csr_data
);
   import cfbp_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // Sequencer: takes a byte only when idle. After an end beat with a character it runs a
   // second step on NUL; after any step that closes a repeat term it runs the repeat walker; then it emits.
   // Emit waits while an older result beat is still stalled.
   cfbp_ctl u_ctl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_field (req_end_of_field),
      .req_stall        (req_stall),
      .sts              (sts),
      .cmd              (cmd)
   );

   // Datapath: parse phase, numbers, sticky error, bitmap, walker, result register.
   // The result register lets the next field start while a result beat waits.
   cfbp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_char_code    (req_char_code),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_value_set    (rsp_value_set),
      .rsp_status       (rsp_status),
      .rsp_was_wildcard (rsp_was_wildcard)
   );

endmodule

// ===== rtl/cfbp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for cron_field_bitmap_parser, attached by bind.
// Depends on cfbp_pkg and the top level's ports.
module cfbp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [7:0]                        req_char_code,
   input logic                              req_end_of_field,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [cfbp_pkg::OUT_BITS-1:0]     rsp_value_set,
   input logic [1:0]                        rsp_status,
   input logic                              rsp_was_wildcard
);
   import cfbp_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_set)
         && $stable(rsp_status) && $stable(rsp_was_wildcard))
      else $error("result beat changed while stalled");

   // an error result carries an empty set and no wildcard flag
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |-> (rsp_value_set == '0) && !rsp_was_wildcard)
      else $error("error result with nonzero payload");

   // a fresh result follows a busy cycle of the emit step
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a busy cycle");

   // the block is busy right after an end beat
   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_field |=> req_stall)
      else $error("end beat did not start result sequence");

   // a stalled input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_char_code)
         && $stable(req_end_of_field))
      else $error("input beat changed while stalled");

endmodule

bind cron_field_bitmap_parser cfbp_checker u_cfbp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_char_code    (req_char_code),
   .req_end_of_field (req_end_of_field),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_value_set    (rsp_value_set),
   .rsp_status       (rsp_status),
   .rsp_was_wildcard (rsp_was_wildcard)
);
